// ===== design/i2cm_pkg.sv =====
// Shared types, command codes and sequence tables for the I2C master bit engine.
`default_nettype none

package i2cm_pkg;

	localparam int DELAY_WIDTH_DEF = 16;
	localparam int CFG_W           = 16;
	localparam logic [CFG_W-1:0] PHASE_DELAY_RST = 16'd100;

	localparam int OP_W   = 3;
	localparam int STEP_W = 5;

	localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
	localparam logic [OP_W-1:0] OP_INIT   = 3'd1;
	localparam logic [OP_W-1:0] OP_START  = 3'd2;
	localparam logic [OP_W-1:0] OP_RSTART = 3'd3;
	localparam logic [OP_W-1:0] OP_STOP   = 3'd4;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;
	localparam logic [OP_W-1:0] OP_READ   = 3'd6;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// residue mod 3 of a 5-bit step index, two bits per entry
	localparam logic [63:0] MOD3_TBL = {4'b0100, {10{6'b100100}}};

	typedef struct packed {
		logic            is_cmd;
		logic [OP_W-1:0] cmd;
		logic [7:0]      tx_byte;
		logic            last_read;
		logic            sda_in;
	} cmd_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic       nack;
		logic [7:0] rx_byte;
		logic       done_res;
		logic       busy_res;
		logic       sda_level;
		logic       scl_level;
	} result_t;

	function automatic logic [STEP_W-1:0] seq_len(input logic [OP_W-1:0] cmd);
		logic [STEP_W-1:0] len;
		unique case (cmd)
			OP_INIT:   len = 5'd2;
			OP_START:  len = 5'd2;
			OP_RSTART: len = 5'd4;
			OP_STOP:   len = 5'd3;
			OP_WRITE:  len = 5'd28;
			OP_READ:   len = 5'd21;
			default:   len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [1:0] mod3(input logic [STEP_W-1:0] v);
		return MOD3_TBL[{v, 1'b0} +: 2];
	endfunction

endpackage

`default_nettype wire

// ===== design/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: front decode, item queue and pin sequencer.
//
// channel  | dir | handshake         | payload
// ---------+-----+-------------------+--------------------------------------------
// s_       | in  | s_tvalid/s_tready | tuser op; tdata tx_byte, last_read, sda_in
// m_       | out | m_tvalid/m_tready | tdata scl, sda, busy, done, rx_byte, nack
// cfg_     | in  | cfg_wr_en         | cfg_wr_data = phase_delay
//
// One item per clock cycle sustained while the result register is free to take it;
// each item is one tick and gives one result. An accepted item is queued, then popped
// into the registered result; the single sequencer step in the back end sets the rate.
// Reset clears the queue, the sequencer to idle with both pins released, and
// sets phase_delay to 100.
// A low m_tready with a result pending holds the result register and stops the back
// end; the two-entry queue then fills and s_tready drops.
`default_nettype none

module i2c_master_bit_engine import i2cm_pkg::*; #(
	parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [15:0]      s_tdata,   // tx_byte[7:0], last_read[8], sda_in[9]
	input  wire logic [7:0]       s_tuser,   // op[2:0]
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [15:0]           m_tdata    // scl[0], sda[1], busy[2], done[3], rx_byte[11:4], nack[12]
);

	q_status_t q_stat;
	cmd_item_t push_item;
	cmd_item_t head;
	logic      push;
	logic      pop;

	i2cm_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	i2cm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	i2cm_back #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue both full and empty");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[2])
		else $error("done result still busy");

endmodule

`default_nettype wire

// ===== design/i2cm_front.sv =====
// Input side: takes stream items, decodes the op field and pushes them to the queue.
`default_nettype none

module i2cm_front import i2cm_pkg::*; (
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // tx_byte[7:0], last_read[8], sda_in[9], zero fill
	input  wire logic [7:0]  s_tuser,   // op[2:0], zero fill
	input  wire q_status_t   q_stat,
	output logic             push,
	output cmd_item_t        push_item
);

	logic [OP_W-1:0] op;

	assign op       = s_tuser[OP_W-1:0];
	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && !q_stat.full;

	always_comb begin
		push_item.is_cmd    = (op >= OP_INIT) && (op <= OP_READ);
		push_item.cmd       = op;
		push_item.tx_byte   = s_tdata[7:0];
		push_item.last_read = s_tdata[8];
		push_item.sda_in    = s_tdata[9];
	end

endmodule

`default_nettype wire

// ===== design/i2cm_queue.sv =====
// Short first-word-fall-through queue of decoded items between front and back.
`default_nettype none

module i2cm_queue import i2cm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire cmd_item_t push_item,
	input  wire logic      pop,
	output cmd_item_t      head,
	output q_status_t      q_stat
);

	cmd_item_t          mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
		return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/i2cm_back.sv =====
// Execution side: pin sequencer state, phase timer and the registered result.
`default_nettype none

module i2cm_back import i2cm_pkg::*; #(
	parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire cmd_item_t        head,
	input  wire q_status_t        q_stat,
	output logic                  pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [15:0]           m_tdata
);

	logic [CFG_W-1:0]       phase_delay_q;
	logic [DELAY_WIDTH-1:0] pd_w;
	logic [DELAY_WIDTH-1:0] reload;

	logic [DELAY_WIDTH-1:0] hold_q, hold_n;
	logic [STEP_W-1:0]      step_q, step_n, step_inc, idx;
	logic [OP_W-1:0]        cmd_q, cmd_n;
	logic [7:0]             shift_q, shift_n, rx_q, rx_n;
	logic                   scl_q, scl_n, sda_q, sda_n;
	logic                   nack_q, nack_n, nar_q, nar_n;
	logic                   done_n, act;
	logic                   out_vld_q;
	result_t                res_q;

	generate
		if (DELAY_WIDTH > CFG_W) begin : g_wide
			assign pd_w = {{(DELAY_WIDTH - CFG_W){1'b0}}, phase_delay_q};
		end else if (DELAY_WIDTH == CFG_W) begin : g_same
			assign pd_w = phase_delay_q;
		end else begin : g_narrow
			assign pd_w = phase_delay_q[DELAY_WIDTH-1:0];
		end
	endgenerate

	assign reload = (pd_w == '0) ? '0 : pd_w - DELAY_WIDTH'(1);
	assign pop    = !q_stat.empty && (!out_vld_q || m_tready);

	always_comb begin
		cmd_n    = cmd_q;
		step_n   = step_q;
		hold_n   = hold_q;
		shift_n  = shift_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		nack_n   = nack_q;
		nar_n    = nar_q;
		rx_n     = rx_q;
		done_n   = 1'b0;
		act      = 1'b0;
		idx      = '0;
		step_inc = step_q + STEP_W'(1);

		if (cmd_q == OP_NONE) begin
			if (head.is_cmd) begin
				cmd_n  = head.cmd;
				step_n = '0;
				if (head.cmd == OP_WRITE) begin
					shift_n = head.tx_byte;
				end
				if (head.cmd == OP_READ) begin
					shift_n = '0;
					nar_n   = head.last_read;
				end
				act = 1'b1;
			end
		end else if (hold_q != '0) begin
			hold_n = hold_q - DELAY_WIDTH'(1);
		end else if (step_inc >= seq_len(cmd_q)) begin
			cmd_n  = OP_NONE;
			step_n = '0;
			done_n = 1'b1;
		end else begin
			step_n = step_inc;
			idx    = step_inc;
			act    = 1'b1;
		end

		if (act) begin
			hold_n = reload;
			unique case (cmd_n)
				OP_INIT: begin
					if (idx == 5'd0) scl_n = 1'b1;
					else sda_n = 1'b1;
				end
				OP_START: begin
					if (idx == 5'd0) sda_n = 1'b0;
					else scl_n = 1'b0;
				end
				OP_RSTART: begin
					if (idx[0]) scl_n = (idx < 5'd2);
					else sda_n = (idx < 5'd2);
				end
				OP_STOP: begin
					if (idx == 5'd0) sda_n = 1'b0;
					else if (idx == 5'd1) scl_n = 1'b1;
					else sda_n = 1'b1;
				end
				OP_WRITE: begin
					if (idx < 5'd24) begin
						unique case (mod3(idx))
							2'd0: sda_n = shift_n[7];
							2'd1: scl_n = 1'b1;
							2'd2: begin
								scl_n   = 1'b0;
								shift_n = {shift_n[6:0], 1'b0};
							end
							default: ;
						endcase
					end else if (idx == 5'd24) begin
						sda_n = 1'b1;
					end else if (idx == 5'd25) begin
						scl_n = 1'b1;
					end else if (idx == 5'd26) begin
						nack_n = head.sda_in;
						scl_n  = 1'b0;
					end else begin
						sda_n = 1'b0;
					end
				end
				OP_READ: begin
					if (idx == 5'd0) begin
						sda_n = 1'b1;
					end else if (idx == 5'd1) begin
						scl_n = 1'b0;
					end else if (idx < 5'd18) begin
						if (!idx[0]) begin
							scl_n = 1'b1;
						end else begin
							shift_n = {shift_n[6:0], head.sda_in};
							scl_n   = 1'b0;
						end
					end else if (idx == 5'd18) begin
						sda_n = nar_n;
					end else if (idx == 5'd19) begin
						scl_n = 1'b1;
					end else begin
						scl_n = 1'b0;
						rx_n  = shift_n;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_delay_q <= PHASE_DELAY_RST;
		end else if (cfg_wr_en) begin
			phase_delay_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q    <= '0;
			step_q    <= '0;
			cmd_q     <= OP_NONE;
			shift_q   <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			nack_q    <= 1'b0;
			nar_q     <= 1'b0;
			rx_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				hold_q    <= hold_n;
				step_q    <= step_n;
				cmd_q     <= cmd_n;
				shift_q   <= shift_n;
				scl_q     <= scl_n;
				sda_q     <= sda_n;
				nack_q    <= nack_n;
				nar_q     <= nar_n;
				rx_q      <= rx_n;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.scl_level <= scl_n;
			res_q.sda_level <= sda_n;
			res_q.busy_res  <= (cmd_n != OP_NONE);
			res_q.done_res  <= done_n;
			res_q.rx_byte   <= rx_n;
			res_q.nack      <= nack_n;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, res_q};

endmodule

`default_nettype wire

// ===== tb/sv/i2cm_bit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the I2C master bit engine: predicts every tick's pin levels and status, then compares.
module i2cm_bit_checker import i2cm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	input  wire logic             s_tvalid,
	input  wire logic             s_tready,
	input  wire logic [15:0]      s_tdata,   // tx_byte[7:0], last_read[8], sda_in[9]
	input  wire logic [7:0]       s_tuser,   // op[2:0]
	input  wire logic             m_tvalid,
	input  wire logic             m_tready,
	input  wire logic [15:0]      m_tdata,   // scl[0], sda[1], busy[2], done[3], rx_byte[11:4], nack[12]
	output int                    fail_count,
	output int                    pending,
	output int                    tick_count,
	output int                    cmd_count
);

	logic [CFG_W-1:0]  delay_cfg;
	logic [CFG_W-1:0]  hold_cnt;
	logic [STEP_W-1:0] step;
	logic [OP_W-1:0]   cmd;
	logic [7:0]        shifter;
	logic [7:0]        rx_last;
	logic              scl_drv;
	logic              sda_drv;
	logic              nack_flag;
	logic              nack_on_read;

	result_t tick_results_q[$];

	function automatic logic [STEP_W-1:0] steps_of(input logic [OP_W-1:0] c);
		case (c)
			OP_INIT, OP_START: return 5'd2;
			OP_RSTART:         return 5'd4;
			OP_STOP:           return 5'd3;
			OP_WRITE:          return 5'd28;
			OP_READ:           return 5'd21;
			default:           return 5'd0;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] reload_value();
		return (delay_cfg == '0) ? '0 : delay_cfg - 1'b1;
	endfunction

	function automatic void drive_pins(input logic sda_smp);
		logic [STEP_W-1:0] i;
		int ph;
		i = step;
		ph = int'(i) % 3;
		case (cmd)
			OP_INIT: begin
				if (i == 0) scl_drv = 1'b1;
				else sda_drv = 1'b1;
			end
			OP_START: begin
				if (i == 0) sda_drv = 1'b0;
				else scl_drv = 1'b0;
			end
			OP_RSTART: begin
				if (i[0]) scl_drv = (i < 2);
				else sda_drv = (i < 2);
			end
			OP_STOP: begin
				if (i == 0) sda_drv = 1'b0;
				else if (i == 1) scl_drv = 1'b1;
				else sda_drv = 1'b1;
			end
			OP_WRITE: begin
				if (i < 24) begin
					if (ph == 0) sda_drv = shifter[7];
					else if (ph == 1) scl_drv = 1'b1;
					else begin
						scl_drv = 1'b0;
						shifter = {shifter[6:0], 1'b0};
					end
				end else if (i == 24) sda_drv = 1'b1;
				else if (i == 25) scl_drv = 1'b1;
				else if (i == 26) begin
					nack_flag = sda_smp;
					scl_drv = 1'b0;
				end else sda_drv = 1'b0;
			end
			OP_READ: begin
				if (i == 0) sda_drv = 1'b1;
				else if (i == 1) scl_drv = 1'b0;
				else if (i < 18) begin
					if (!i[0]) scl_drv = 1'b1;
					else begin
						shifter = {shifter[6:0], sda_smp};
						scl_drv = 1'b0;
					end
				end else if (i == 18) sda_drv = nack_on_read;
				else if (i == 19) scl_drv = 1'b1;
				else begin
					scl_drv = 1'b0;
					rx_last = shifter;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic result_t predict_tick(input logic [OP_W-1:0] op, input logic [7:0] tx,
			input logic last, input logic sda);
		result_t r;
		logic fin;
		fin = 1'b0;
		if (cmd == OP_NONE) begin
			if (op >= OP_INIT && op <= OP_READ) begin
				cmd = op;
				step = '0;
				if (op == OP_WRITE) shifter = tx;
				if (op == OP_READ) begin
					shifter = '0;
					nack_on_read = last;
				end
				drive_pins(sda);
				hold_cnt = reload_value();
			end
		end else if (hold_cnt != '0) begin
			hold_cnt = hold_cnt - 1'b1;
		end else begin
			step = step + 1'b1;
			if (step >= steps_of(cmd)) begin
				cmd = OP_NONE;
				step = '0;
				fin = 1'b1;
			end else begin
				drive_pins(sda);
				hold_cnt = reload_value();
			end
		end
		r.scl_level = scl_drv;
		r.sda_level = sda_drv;
		r.busy_res  = (cmd != OP_NONE);
		r.done_res  = fin;
		r.rx_byte   = rx_last;
		r.nack      = nack_flag;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want_v, input logic [7:0] got_v);
		if (want_v !== got_v) begin
			fail_count++;
			$error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			delay_cfg    = PHASE_DELAY_RST;
			hold_cnt     = '0;
			step         = '0;
			cmd          = OP_NONE;
			shifter      = '0;
			rx_last      = '0;
			scl_drv      = 1'b1;
			sda_drv      = 1'b1;
			nack_flag    = 1'b0;
			nack_on_read = 1'b0;
			tick_results_q.delete();
			fail_count   = 0;
			pending      = 0;
			tick_count   = 0;
			cmd_count    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[12:0]);
				if (tick_results_q.size() == 0) begin
					fail_count++;
					$error("unexpected result transaction: m_tdata %0h", m_tdata);
				end else begin
					want = tick_results_q.pop_front();
					check_field("scl_level", want.scl_level, got.scl_level);
					check_field("sda_level", want.sda_level, got.sda_level);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("done_res", want.done_res, got.done_res);
					check_field("rx_byte", want.rx_byte, got.rx_byte);
					check_field("nack", want.nack, got.nack);
					check_field("m_tdata padding", 8'd0, m_tdata[15:13]);
					tick_count++;
				end
			end
			if (s_tvalid && s_tready) begin
				want = predict_tick(s_tuser[OP_W-1:0], s_tdata[7:0], s_tdata[8], s_tdata[9]);
				if (want.done_res) cmd_count++;
				tick_results_q.push_back(want);
			end
			if (cfg_wr_en) delay_cfg = cfg_wr_data;
			pending = tick_results_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_i2c_master_bit_engine.sv =====
`timescale 1ns / 1ps
// Testbench top for the I2C master bit engine: clock, reset, stimulus phases and verdict.
module tb_i2c_master_bit_engine;
	import i2cm_pkg::*;

	localparam int QUIET_LIMIT = 5000;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [15:0]      s_tdata;   // tx_byte[7:0], last_read[8], sda_in[9]
	logic [7:0]       s_tuser;   // op[2:0]
	logic             m_tvalid;
	logic             m_tready;
	logic [15:0]      m_tdata;   // scl[0], sda[1], busy[2], done[3], rx_byte[11:4], nack[12]

	int fail_count;
	int pending;
	int tick_count;
	int cmd_count;
	int idle_pct = 0;
	int stall_pct = 0;
	int holdoff_len = 0;
	int quiet_cycles = 0;

	i2c_master_bit_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	i2cm_bit_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.pending     (pending),
		.tick_count  (tick_count),
		.cmd_count   (cmd_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_len > 0) begin
				m_tready <= 1'b0;
				holdoff_len--;
			end else m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else quiet_cycles <= quiet_cycles + 1;
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [7:0] tx, input logic last,
			input logic sda);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {5'd0, op};
		s_tdata  <= {6'd0, sda, last, tx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// sda_mode: 0 or 1 holds SDA at that level, values above 1 randomize it
	task automatic send_ticks(input int n, input int sda_mode);
		for (int k = 0; k < n; k++)
			send_item(OP_NONE, 8'($urandom), 1'($urandom),
				(sda_mode > 1) ? 1'($urandom) : 1'(sda_mode));
	endtask

	task automatic send_random(input int n);
		for (int k = 0; k < n; k++)
			send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_delay(input logic [CFG_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic run_phase(input int idle, input int stall, input int n);
		idle_pct  = idle;
		stall_pct = stall;
		send_random(n);
		settle();
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the phase delay
		send_item(OP_INIT, 8'h00, 1'b0, 1'b1);
		send_ticks(210, 2);
		settle();

		// long hold per pin change
		set_delay(16'd40);
		send_item(OP_START, 8'hFF, 1'b1, 1'b0);
		send_ticks(2 * 40 + 8, 2);
		settle();

		set_delay(16'd1);
		send_item(OP_INIT, 8'h00, 1'b0, 1'b1);
		send_ticks(6, 1);
		send_item(OP_START, 8'h00, 1'b0, 1'b1);
		send_ticks(6, 1);
		send_item(OP_WRITE, 8'hFF, 1'b0, 1'b0);
		send_ticks(32, 0);
		send_item(OP_WRITE, 8'h00, 1'b1, 1'b1);
		send_ticks(32, 1);
		send_item(OP_WRITE, 8'hA5, 1'b0, 1'b0);
		send_item(OP_READ, 8'h5A, 1'b1, 1'b1);
		send_ticks(32, 2);
		send_item(OP_RSTART, 8'h00, 1'b0, 1'b1);
		send_ticks(10, 2);
		send_item(OP_READ, 8'h00, 1'b0, 1'b1);
		send_ticks(25, 1);
		send_item(OP_READ, 8'hFF, 1'b1, 1'b0);
		send_ticks(25, 0);
		send_item(3'($urandom_range(7, 7)), 8'hFF, 1'b1, 1'b1);
		send_ticks(3, 2);
		send_item(OP_STOP, 8'h00, 1'b0, 1'b0);
		send_ticks(8, 2);
		settle();

		// zero delay acts as one tick
		set_delay(16'd0);
		run_phase(0, 0, 100);

		set_delay(16'd1);
		run_phase(74, 0, 160);

		set_delay(16'd2);
		idle_pct  = 0;
		stall_pct = 74;
		send_random(60);
		holdoff_len = 400;
		send_random(60);
		settle();
		send_random(60);
		settle();

		set_delay(16'd3);
		run_phase(8, 8, 160);

		set_delay(16'($urandom_range(4, 9)));
		run_phase(0, 0, 160);

		$display("Covered %0d ticks and %0d finished bus commands at phase delays 0 to 100.",
			tick_count, cmd_count);
		$display("Flow control: free running, heavy source gaps, heavy sink stalls, light gaps on"
			, " both sides and a long sink hold-off.");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
